/* rtl/scl_pkg.sv */
// shared types and constants for the shell command lexer
// no dependencies; imported by the interfaces and every module

package scl_pkg;

  localparam int CharWidth = 8;
  localparam int KindWidth = 2;

  typedef logic [CharWidth-1:0] char_t;

  // token kinds as seen on the result channel
  typedef enum logic [KindWidth-1:0] {
    KIND_NORMAL   = 2'd0,
    KIND_QUOTED   = 2'd1,
    KIND_OPERATOR = 2'd2,
    KIND_VARIABLE = 2'd3
  } kind_t;

  // first byte of an operator that may pair with an equal byte
  typedef enum logic [1:0] {
    PAIR_NONE = 2'd0,
    PAIR_GT   = 2'd1,
    PAIR_AMP  = 2'd2,
    PAIR_BAR  = 2'd3
  } pair_t;

  localparam char_t ChSpace  = 8'h20;
  localparam char_t ChTab    = 8'h09;
  localparam char_t ChCr     = 8'h0D;
  localparam char_t ChDquote = 8'h22;
  localparam char_t ChSquote = 8'h27;
  localparam char_t ChDollar = 8'h24;
  localparam char_t ChBar    = 8'h7C;
  localparam char_t ChAmp    = 8'h26;
  localparam char_t ChSemi   = 8'h3B;
  localparam char_t ChLt     = 8'h3C;
  localparam char_t ChGt     = 8'h3E;

  // character class of one byte
  typedef struct packed {
    logic  is_space;
    logic  is_quote;
    logic  is_single;
    logic  is_operator;
    logic  is_dollar;
    pair_t pair;
  } char_class_t;

  // classification of one byte
  typedef struct packed {
    logic  token_begin;
    logic  in_text;
    kind_t token_kind;
  } lex_result_t;

endpackage

/* rtl/scl_if.sv */
// beat channels of the shell command lexer: byte input and classified output
// depends on scl_pkg

interface scl_char_if;
  import scl_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_in;
  logic  line_end;

  modport source (output valid, output char_in, output line_end, input ready);
  modport sink (input valid, input char_in, input line_end, output ready);
endinterface

interface scl_token_if;
  import scl_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_out;
  logic  token_begin;
  logic  in_text;
  kind_t token_kind;
  logic  line_done;

  modport source (
    output valid, output char_out, output token_begin, output in_text,
    output token_kind, output line_done, input ready
  );
  modport sink (
    input valid, input char_out, input token_begin, input in_text,
    input token_kind, input line_done, output ready
  );
endinterface

/* rtl/shell_command_lexer_top.sv */
// top level of the shell command lexer: input register, lexer, result register
// depends on scl_pkg, scl_if, scl_char_class and scl_lexer_core

// Shell command lexer, one byte per beat.
// chars: input channel, one byte of a command line per beat, line_end set
//   on the last byte of a line.
// tokens: result channel, one beat per input beat in the same order, with
//   the byte passed through, token_begin, in_text, token_kind and line_done.
// Kinds: normal word, quoted text (quote marks are not text), operator
//   (| & ; < > and the pairs >> && ||) and variable ($ up to whitespace).
// A byte accepted on chars passes the input register, then the result
//   register, before it is presented on tokens.
// Throughput: one byte per cycle while tokens is ready; the lexer state is a single small state
//   update between the input register and the result register, so each byte
//   sees the state left by the one before it in the same cycle it moves on.
// Stall: when tokens is not ready, the result register holds its beat, the
//   input register holds its byte and the lexer state does not move; chars
//   keeps taking a byte as long as the input register is empty.
// Reset: rst is synchronous; both registers empty, the lexer returns to
//   between tokens. After a byte with line_end the lexer also returns there.

module shell_command_lexer_top (
  input logic        clk,
  input logic        rst,
  scl_char_if.sink   chars,
  scl_token_if.source tokens
);
  import scl_pkg::*;

  // input register
  logic  in_valid;
  char_t in_char;
  logic  in_line_end;

  // result register
  logic        out_valid;
  char_t       out_char;
  lex_result_t out_res;
  logic        out_line_end;

  char_class_t cls;
  lex_result_t res;
  logic        out_load;
  logic        advance;

  // result register takes a new beat when empty or being drained
  assign out_load = !out_valid || tokens.ready;
  // byte in the input register is classified and moves on this cycle
  assign advance  = in_valid && out_load;

  assign chars.ready = !in_valid || out_load;

  scl_char_class u_class (
    .ch  (in_char),
    .cls (cls)
  );

  // lexer state moves only together with its byte
  scl_lexer_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .cls      (cls),
    .line_end (in_line_end),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
    if (chars.valid && chars.ready) begin
      in_char     <= chars.char_in;
      in_line_end <= chars.line_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_char     <= in_char;
      out_res      <= res;
      out_line_end <= in_line_end;
    end
  end

  assign tokens.valid       = out_valid;
  assign tokens.char_out    = out_char;
  assign tokens.token_begin = out_res.token_begin;
  assign tokens.in_text     = out_res.in_text;
  assign tokens.token_kind  = out_res.token_kind;
  assign tokens.line_done   = out_line_end;

endmodule

/* rtl/scl_char_class.sv */
// byte classifier: whitespace, quotes, operators, dollar and pair code
// depends on scl_pkg

module scl_char_class (
  input  scl_pkg::char_t       ch,
  output scl_pkg::char_class_t cls
);
  import scl_pkg::*;

  always_comb begin
    cls.is_space    = (ch == ChSpace) || (ch >= ChTab && ch <= ChCr);
    cls.is_quote    = (ch == ChDquote) || (ch == ChSquote);
    cls.is_single   = (ch == ChSquote);
    cls.is_operator = (ch == ChBar) || (ch == ChAmp) || (ch == ChSemi) ||
                      (ch == ChLt) || (ch == ChGt);
    cls.is_dollar   = (ch == ChDollar);
    case (ch)
      ChGt:    cls.pair = PAIR_GT;
      ChAmp:   cls.pair = PAIR_AMP;
      ChBar:   cls.pair = PAIR_BAR;
      default: cls.pair = PAIR_NONE;
    endcase
  end

endmodule

/* rtl/scl_lexer_core.sv */
// lexer state machine: classifies one byte from its class and the lexer state
// depends on scl_pkg; state advances only when step is high

module scl_lexer_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  scl_pkg::char_class_t cls,
  input  logic                 line_end,
  output scl_pkg::lex_result_t res
);
  import scl_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_NORMAL   = 3'd1,
    MODE_QUOTED   = 3'd2,
    MODE_VARIABLE = 3'd3,
    MODE_OPERATOR = 3'd4
  } mode_t;

  mode_t mode, mode_next;
  logic  quote_single, quote_single_next;
  pair_t pending, pending_next;
  logic  fresh;

  always_comb begin
    mode_next         = mode;
    quote_single_next = quote_single;
    pending_next      = pending;
    res               = '0;
    fresh             = 1'b0;

    case (mode)
      MODE_QUOTED: begin
        res.token_kind = KIND_QUOTED;
        if (cls.is_quote && (cls.is_single == quote_single)) begin
          mode_next = MODE_IDLE;
        end else begin
          res.in_text = 1'b1;
        end
      end
      MODE_VARIABLE: begin
        if (cls.is_space) begin
          mode_next = MODE_IDLE;
        end else begin
          res.in_text    = 1'b1;
          res.token_kind = KIND_VARIABLE;
        end
      end
      MODE_NORMAL: begin
        if (cls.is_space) begin
          mode_next = MODE_IDLE;
        end else if (cls.is_operator || cls.is_quote) begin
          fresh = 1'b1;
        end else begin
          res.in_text = 1'b1;
        end
      end
      MODE_OPERATOR: begin
        if (pending != PAIR_NONE && cls.pair == pending) begin
          res.in_text    = 1'b1;
          res.token_kind = KIND_OPERATOR;
          mode_next      = MODE_IDLE;
          pending_next   = PAIR_NONE;
        end else begin
          pending_next = PAIR_NONE;
          fresh        = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // byte handled as if between tokens
    if (fresh) begin
      mode_next    = MODE_IDLE;
      pending_next = PAIR_NONE;
      if (cls.is_space) begin
        res = '0;
      end else if (cls.is_quote) begin
        res.token_begin   = 1'b1;
        res.in_text       = 1'b0;
        res.token_kind    = KIND_QUOTED;
        quote_single_next = cls.is_single;
        mode_next         = MODE_QUOTED;
      end else if (cls.is_operator) begin
        res.token_begin = 1'b1;
        res.in_text     = 1'b1;
        res.token_kind  = KIND_OPERATOR;
        pending_next    = cls.pair;
        if (cls.pair != PAIR_NONE) begin
          mode_next = MODE_OPERATOR;
        end
      end else if (cls.is_dollar) begin
        res.token_begin = 1'b1;
        res.in_text     = 1'b1;
        res.token_kind  = KIND_VARIABLE;
        mode_next       = MODE_VARIABLE;
      end else begin
        res.token_begin = 1'b1;
        res.in_text     = 1'b1;
        res.token_kind  = KIND_NORMAL;
        mode_next       = MODE_NORMAL;
      end
    end

    // last byte of the line leaves everything as after reset
    if (line_end) begin
      mode_next         = MODE_IDLE;
      quote_single_next = 1'b0;
      pending_next      = PAIR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      quote_single <= 1'b0;
      pending      <= PAIR_NONE;
    end else if (step) begin
      mode         <= mode_next;
      quote_single <= quote_single_next;
      pending      <= pending_next;
    end
  end

endmodule
